// ----- hw/rtl/cifq_pkg.sv -----
// Shared types and constants for the compressed instruction fetch queue.
`default_nettype none
package cifq_pkg;

   localparam int QUEUE_DEPTH         = 16;
   localparam int QUEUE_AW            = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W              = $clog2(QUEUE_DEPTH + 1);
   localparam int HALFWORDS_PER_FETCH = 4;
   localparam int POS_W               = $clog2(HALFWORDS_PER_FETCH + 1);
   localparam int HW_IDX_W            = $clog2(HALFWORDS_PER_FETCH);

   localparam int PC_W    = 64;
   localparam int WORD_W  = 32;
   localparam int SEQ_W   = 32;
   localparam int ENTRY_W = PC_W + WORD_W + SEQ_W;

   localparam int LIMIT_W = 3;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_HALFWORD_LIMIT = 1'b0;

   localparam logic [1:0] LOW_BITS_MASK = 2'b11;
   localparam logic [1:0] WIDE_FORM     = 2'b11;

   typedef enum logic {
      OP_FETCH   = 1'b0,
      OP_RELEASE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_READ,
      ST_RESP
   } state_type;

   // Result of one step of the shared split unit
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              wide;
      logic              at_end;
      logic [PC_W-1:0]   pc_next;
   } step_type;

endpackage
`default_nettype wire

// ----- hw/rtl/compressed_insn_fetch_queue_unit.sv -----
// Top level of the compressed instruction fetch queue.
// A fetch queues N instructions (0..4), one per split step, then raises rsp_valid; a release
//   with a non-empty queue does a registered RAM read first, an empty release does not.
// A new start is accepted only once the unit is idle again; busy stays high through the
//   rsp_valid cycle, which lasts one cycle.
// Synchronous active-high reset empties the queue, clears the sequence counter and
//   sets halfword_limit to 4; queue RAM contents are not cleared.
`default_nettype none
module compressed_insn_fetch_queue_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // transaction input
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_opcode,
   input  wire logic [63:0]                  req_fetch_pc,
   input  wire logic [15:0]                  req_halfword0,
   input  wire logic [15:0]                  req_halfword1,
   input  wire logic [15:0]                  req_halfword2,
   input  wire logic [15:0]                  req_halfword3,
   // result
   output logic                              rsp_valid,
   output logic [63:0]                       rsp_next_pc,
   output logic [2:0]                        rsp_queued_count,
   output logic                              rsp_insn_valid,
   output logic [63:0]                       rsp_insn_address,
   output logic [31:0]                       rsp_insn_word,
   output logic [31:0]                       rsp_insn_sequence,
   output logic                              rsp_queue_empty,
   // APB register port
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [cifq_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cifq_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [cifq_pkg::CSR_DATA_W-1:0] prdata,
   output logic                              pready
);
   import cifq_pkg::*;

   // control state
   state_type           state_ff, state_in;
   logic [QUEUE_AW-1:0] head_ff, head_in;
   logic [QUEUE_AW-1:0] tail_ff, tail_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;

   // working transaction
   logic [PC_W-1:0]                          pc_ff, pc_in;
   logic [HALFWORDS_PER_FETCH-1:0][15:0]     hw_ff, hw_in;
   logic [POS_W-1:0]                         pos_ff, pos_in;
   logic [2:0]                               queued_ff, queued_in;
   logic                                     r_valid_ff, r_valid_in;
   logic [PC_W-1:0]                          r_addr_ff, r_addr_in;
   logic [WORD_W-1:0]                        r_word_ff, r_word_in;
   logic [SEQ_W-1:0]                         r_seq_ff, r_seq_in;

   logic       accept;
   logic       csr_write;
   logic       split_stop;
   logic       push;
   logic       pop;
   logic       rd_en;
   logic       queue_has;
   step_type   step;
   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] wr_data;

   assign accept    = start && !busy;
   assign queue_has = fill_ff != FILL_W'(0);
   assign csr_write = psel && penable && pwrite && pready;

   // ---------------- shared split unit ----------------
   cifq_step u_step (
      .halfwords (hw_ff),
      .pos       (pos_ff[HW_IDX_W-1:0]),
      .pc        (pc_ff),
      .step      (step)
   );

   // Split ends at the fetch width, at the configured limit, on a full queue,
   // or when a wide form would straddle the end of the bundle.
   assign split_stop = (pos_ff >= POS_W'(limit_ff))
                    || (pos_ff >= POS_W'(HALFWORDS_PER_FETCH))
                    || (fill_ff == FILL_W'(QUEUE_DEPTH))
                    || step.at_end;

   // ---------------- queue storage ----------------
   assign wr_data = {pc_ff, step.word, seq_ff};

   cifq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (opcode_type'(req_opcode) == OP_FETCH) begin
                  state_in = ST_SPLIT;
               end else if (queue_has) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SPLIT: begin
            if (split_stop) begin
               state_in = ST_RESP;
            end
         end
         ST_READ: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      push      = 1'b0;
      pop       = 1'b0;
      rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy  = 1'b0;
            rd_en = accept && (opcode_type'(req_opcode) == OP_RELEASE) && queue_has;
         end
         ST_SPLIT: push = !split_stop;
         ST_READ:  pop = 1'b1;
         ST_RESP:  rsp_valid = 1'b1;
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      seq_in     = seq_ff;
      pc_in      = pc_ff;
      hw_in      = hw_ff;
      pos_in     = pos_ff;
      queued_in  = queued_ff;
      r_valid_in = r_valid_ff;
      r_addr_in  = r_addr_ff;
      r_word_in  = r_word_ff;
      r_seq_in   = r_seq_ff;

      if (accept) begin
         pc_in      = req_fetch_pc;
         hw_in      = {req_halfword3, req_halfword2, req_halfword1, req_halfword0};
         pos_in     = POS_W'(0);
         queued_in  = 3'd0;
         r_valid_in = 1'b0;
         r_addr_in  = '0;
         r_word_in  = '0;
         r_seq_in   = '0;
      end

      if (push) begin
         tail_in   = (tail_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QUEUE_AW'(1);
         fill_in   = fill_ff + FILL_W'(1);
         seq_in    = seq_ff + SEQ_W'(1);
         pc_in     = step.pc_next;
         pos_in    = pos_ff + (step.wide ? POS_W'(2) : POS_W'(1));
         queued_in = queued_ff + 3'd1;
      end

      if (pop) begin
         head_in    = (head_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QUEUE_AW'(1);
         fill_in    = fill_ff - FILL_W'(1);
         r_valid_in = 1'b1;
         r_addr_in  = rd_data[ENTRY_W-1 -: PC_W];
         r_word_in  = rd_data[SEQ_W +: WORD_W];
         r_seq_in   = rd_data[SEQ_W-1:0];
      end
   end

   // ---------------- register file ----------------
   always_comb begin
      limit_in = limit_ff;
      if (csr_write && (paddr[CSR_ADDR_W-1] == REG_HALFWORD_LIMIT)) begin
         limit_in = pwdata[LIMIT_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1] == REG_HALFWORD_LIMIT)
                 ? CSR_DATA_W'(limit_ff) : '0;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         fill_ff  <= '0;
         seq_ff   <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
         seq_ff   <= seq_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff      <= pc_in;
      hw_ff      <= hw_in;
      pos_ff     <= pos_in;
      queued_ff  <= queued_in;
      r_valid_ff <= r_valid_in;
      r_addr_ff  <= r_addr_in;
      r_word_ff  <= r_word_in;
      r_seq_ff   <= r_seq_in;
   end

   // ---------------- result ports ----------------
   // pc_ff holds the advanced PC for a fetch and the echoed PC for a release.
   assign rsp_next_pc       = pc_ff;
   assign rsp_queued_count  = queued_ff;
   assign rsp_insn_valid    = r_valid_ff;
   assign rsp_insn_address  = r_addr_ff;
   assign rsp_insn_word     = r_word_ff;
   assign rsp_insn_sequence = r_seq_ff;
   assign rsp_queue_empty   = !queue_has;

   // ---------------- assertions ----------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("queue fill exceeds depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (fill_ff != FILL_W'(QUEUE_DEPTH)))
      else $error("push into full queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_has)
      else $error("pop from empty queue");

   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   a_release_no_push: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_insn_valid) |-> (rsp_queued_count == 3'd0))
      else $error("release reported queued instructions");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after accept");

endmodule
`default_nettype wire

// ----- hw/rtl/cifq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cifq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/cifq_step.sv -----
// Shared split unit: decodes one instruction at a halfword position and advances the PC.
`default_nettype none
module cifq_step (
   input  wire logic [cifq_pkg::HALFWORDS_PER_FETCH-1:0][15:0] halfwords,
   input  wire logic [cifq_pkg::HW_IDX_W-1:0]                  pos,
   input  wire logic [cifq_pkg::PC_W-1:0]                      pc,
   output cifq_pkg::step_type                                  step
);
   import cifq_pkg::*;

   logic [15:0]         low_hw;
   logic [15:0]         high_hw;
   logic [HW_IDX_W-1:0] pos_up;
   logic                wide;

   assign pos_up  = pos + HW_IDX_W'(1);
   assign low_hw  = halfwords[pos];
   assign high_hw = halfwords[pos_up];
   assign wide    = (low_hw[1:0] & LOW_BITS_MASK) == WIDE_FORM;

   always_comb begin
      step.wide    = wide;
      // wide form whose upper half lies past the bundle
      step.at_end  = wide && (pos == HW_IDX_W'(HALFWORDS_PER_FETCH - 1));
      step.word    = wide ? {high_hw, low_hw} : {16'h0000, low_hw};
      step.pc_next = pc + (wide ? PC_W'(4) : PC_W'(2));
   end

endmodule
`default_nettype wire

// ----- sim/compressed_insn_fetch_queue_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the fetch queue: mirrors the queue, predicts each reply and compares it.
module compressed_insn_fetch_queue_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic                            req_opcode,
   input  wire logic [63:0]                     req_fetch_pc,
   input  wire logic [15:0]                     req_halfword0,
   input  wire logic [15:0]                     req_halfword1,
   input  wire logic [15:0]                     req_halfword2,
   input  wire logic [15:0]                     req_halfword3,
   input  wire logic                            rsp_valid,
   input  wire logic [63:0]                     rsp_next_pc,
   input  wire logic [2:0]                      rsp_queued_count,
   input  wire logic                            rsp_insn_valid,
   input  wire logic [63:0]                     rsp_insn_address,
   input  wire logic [31:0]                     rsp_insn_word,
   input  wire logic [31:0]                     rsp_insn_sequence,
   input  wire logic                            rsp_queue_empty,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [cifq_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cifq_pkg::CSR_DATA_W-1:0] pwdata,
   input  wire logic [cifq_pkg::CSR_DATA_W-1:0] prdata,
   input  wire logic                            pready,
   output int                                   errors,
   output int                                   pending,
   output int                                   insns_queued,
   output int                                   wide_queued,
   output int                                   insns_released,
   output int                                   empty_releases,
   output int                                   full_cuts
);
   import cifq_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = {REG_HALFWORD_LIMIT, 2'b00};

   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic [2:0]        queued_count;
      logic              insn_valid;
      logic [PC_W-1:0]   insn_address;
      logic [WORD_W-1:0] insn_word;
      logic [SEQ_W-1:0]  insn_sequence;
      logic              queue_empty;
   } fetch_reply_type;

   fetch_reply_type awaited_replies[$];

   // mirror of the instruction queue
   logic [PC_W-1:0]   slot_pc   [QUEUE_DEPTH];
   logic [WORD_W-1:0] slot_word [QUEUE_DEPTH];
   logic [SEQ_W-1:0]  slot_seq  [QUEUE_DEPTH];
   int unsigned       head;
   int unsigned       fill;
   logic [SEQ_W-1:0]  seq_next;
   logic [LIMIT_W-1:0] limit;

   initial begin
      errors = 0;
      pending = 0;
      insns_queued = 0;
      wide_queued = 0;
      insns_released = 0;
      empty_releases = 0;
      full_cuts = 0;
   end

   function automatic fetch_reply_type split_or_release(opcode_type op, logic [63:0] pc,
                                                        logic [63:0] bundle);
      fetch_reply_type reply;
      int unsigned  pos;
      int unsigned  tail;
      logic [15:0]  lo;
      logic [31:0]  word;
      logic [2:0]   len;
      reply = '0;
      pos = 0;
      if (op == OP_FETCH) begin
         for (int i = 0; i < HALFWORDS_PER_FETCH; i++) begin
            if (pos >= limit || pos >= HALFWORDS_PER_FETCH || fill >= QUEUE_DEPTH) begin
               if (fill >= QUEUE_DEPTH && pos < limit && pos < HALFWORDS_PER_FETCH)
                  full_cuts++;
               break;
            end
            lo = bundle[16*pos +: 16];
            if ((lo[1:0] & LOW_BITS_MASK) == WIDE_FORM) begin
               // 32-bit form needs the next halfword inside this bundle
               if (pos + 1 >= HALFWORDS_PER_FETCH)
                  break;
               word = {bundle[16*(pos+1) +: 16], lo};
               len = 3'd4;
               pos += 2;
               wide_queued++;
            end else begin
               word = {16'h0000, lo};
               len = 3'd2;
               pos += 1;
            end
            tail = (head + fill) % QUEUE_DEPTH;
            slot_pc[tail] = pc;
            slot_word[tail] = word;
            slot_seq[tail] = seq_next;
            seq_next = seq_next + 1'b1;
            fill++;
            reply.queued_count = reply.queued_count + 1'b1;
            insns_queued++;
            pc = pc + 64'(len);
         end
      end else if (fill != 0) begin
         reply.insn_valid = 1'b1;
         reply.insn_address = slot_pc[head];
         reply.insn_word = slot_word[head];
         reply.insn_sequence = slot_seq[head];
         head = (head + 1) % QUEUE_DEPTH;
         fill--;
         insns_released++;
      end else begin
         empty_releases++;
      end
      reply.next_pc = pc;
      reply.queue_empty = (fill == 0);
      return reply;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch
      fetch_reply_type want;
      if (reset) begin
         head = 0;
         fill = 0;
         seq_next = '0;
         limit = LIMIT_RESET;
         awaited_replies.delete();
      end else begin
         // reply leaves before a new transaction is predicted
         if (rsp_valid) begin
            if (awaited_replies.size() == 0) begin
               $error("reply with no transaction outstanding");
               errors++;
            end else begin
               want = awaited_replies.pop_front();
               check_field("next_pc", want.next_pc, rsp_next_pc);
               check_field("queued_count", 64'(want.queued_count), 64'(rsp_queued_count));
               check_field("insn_valid", 64'(want.insn_valid), 64'(rsp_insn_valid));
               check_field("insn_address", want.insn_address, rsp_insn_address);
               check_field("insn_word", 64'(want.insn_word), 64'(rsp_insn_word));
               check_field("insn_sequence", 64'(want.insn_sequence), 64'(rsp_insn_sequence));
               check_field("queue_empty", 64'(want.queue_empty), 64'(rsp_queue_empty));
            end
         end
         if (start && !busy)
            awaited_replies.push_back(split_or_release(opcode_type'(req_opcode), req_fetch_pc,
               {req_halfword3, req_halfword2, req_halfword1, req_halfword0}));
         if (psel && penable && pready && paddr == LIMIT_ADDR) begin
            if (pwrite)
               limit = pwdata[LIMIT_W-1:0];
            else
               check_field("halfword_limit", 64'(limit), 64'(prdata));
         end
      end
      pending = awaited_replies.size();
   end

endmodule

// ----- sim/tb_compressed_insn_fetch_queue_unit.sv -----
`timescale 1ns / 1ps
// Testbench top for the fetch queue: stimulus, register setup, watchdog and verdict.
module tb_compressed_insn_fetch_queue_unit;
   import cifq_pkg::*;

   localparam int WATCHDOG_CYCLES = 2000;
   localparam int PHASE_ITEMS     = 200;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = {REG_HALFWORD_LIMIT, 2'b00};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        req_opcode = 1'b0;
   logic [63:0] req_fetch_pc = '0;
   logic [15:0] req_halfword0 = '0;
   logic [15:0] req_halfword1 = '0;
   logic [15:0] req_halfword2 = '0;
   logic [15:0] req_halfword3 = '0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;

   wire logic        busy;
   wire logic        rsp_valid;
   wire logic [63:0] rsp_next_pc;
   wire logic [2:0]  rsp_queued_count;
   wire logic        rsp_insn_valid;
   wire logic [63:0] rsp_insn_address;
   wire logic [31:0] rsp_insn_word;
   wire logic [31:0] rsp_insn_sequence;
   wire logic        rsp_queue_empty;
   wire logic [CSR_DATA_W-1:0] prdata;
   wire logic        pready;

   int errors, pending;
   int insns_queued, wide_queued, insns_released, empty_releases, full_cuts;
   int transactions = 0;
   int idle_cycles = 0;
   bit no_gaps = 1'b0;

   // limit settings swept after the directed part; out-of-range values included
   int unsigned limit_plan[8] = '{1, 2, 3, 0, 5, 6, 7, 4};

   always #5 clock = ~clock;

   compressed_insn_fetch_queue_unit uut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_fetch_pc(req_fetch_pc),
      .req_halfword0(req_halfword0), .req_halfword1(req_halfword1),
      .req_halfword2(req_halfword2), .req_halfword3(req_halfword3),
      .rsp_valid(rsp_valid), .rsp_next_pc(rsp_next_pc),
      .rsp_queued_count(rsp_queued_count), .rsp_insn_valid(rsp_insn_valid),
      .rsp_insn_address(rsp_insn_address), .rsp_insn_word(rsp_insn_word),
      .rsp_insn_sequence(rsp_insn_sequence), .rsp_queue_empty(rsp_queue_empty),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   compressed_insn_fetch_queue_checker scoreboard (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_fetch_pc(req_fetch_pc),
      .req_halfword0(req_halfword0), .req_halfword1(req_halfword1),
      .req_halfword2(req_halfword2), .req_halfword3(req_halfword3),
      .rsp_valid(rsp_valid), .rsp_next_pc(rsp_next_pc),
      .rsp_queued_count(rsp_queued_count), .rsp_insn_valid(rsp_insn_valid),
      .rsp_insn_address(rsp_insn_address), .rsp_insn_word(rsp_insn_word),
      .rsp_insn_sequence(rsp_insn_sequence), .rsp_queue_empty(rsp_queue_empty),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .errors(errors), .pending(pending),
      .insns_queued(insns_queued), .wide_queued(wide_queued),
      .insns_released(insns_released), .empty_releases(empty_releases),
      .full_cuts(full_cuts)
   );

   // One transaction: optional gap with start low, then hold start until !busy at an edge.
   // Called and returns at a falling edge; start stays high when the next gap is zero.
   task automatic issue(opcode_type op, logic [63:0] pc, logic [63:0] bundle);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_opcode = op;
      req_fetch_pc = pc;
      {req_halfword3, req_halfword2, req_halfword1, req_halfword0} = bundle;
      do @(posedge clock); while (busy);
      transactions++;
      @(negedge clock);
   endtask

   // APB setup + access; the access completes at the edge where pready is high
   task automatic csr_access(logic write, logic [CSR_DATA_W-1:0] data);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = write;
      paddr = LIMIT_ADDR;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // drop start so the last transaction is not taken again, then wait for the block to idle;
   // every transaction yields a reply, so an empty scoreboard means the block is idle
   task automatic settle();
      start = 1'b0;
      while (pending != 0 || busy) @(negedge clock);
   endtask

   // Mostly well-formed halfwords: about half start a 32-bit form, plus all-0 / all-1
   function automatic logic [15:0] random_halfword();
      logic [15:0] hw;
      hw = 16'($urandom);
      case ($urandom_range(0, 7))
         0: hw = 16'h0000;
         1: hw = 16'hFFFF;
         2, 3, 4: hw[1:0] = WIDE_FORM;
         default: if (hw[1:0] == WIDE_FORM) hw[1:0] = 2'($urandom_range(0, 2));
      endcase
      return hw;
   endfunction

   // occasional PCs just below the top of the address space to exercise wrap
   function automatic logic [63:0] random_pc();
      if ($urandom_range(0, 15) == 0)
         return 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15));
      return {$urandom, $urandom};
   endfunction

   initial begin : stimulus
      int         fetch_pct;
      int         mood_left;
      bit         filling;
      opcode_type op;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed part, reset limit of four halfwords ----
      issue(OP_RELEASE, 64'h0, 64'h0);                              // release on empty queue
      issue(OP_FETCH, 64'h0, 64'h0);                                // four 16-bit forms
      issue(OP_FETCH, '1, '1);                                      // two 32-bit, PC wraps
      issue(OP_FETCH, 64'hFFFF_FFFF_FFFF_FFFC,
            {16'h0003, 16'h0002, 16'h0001, 16'h0000});              // 32-bit split at end
      issue(OP_FETCH, 64'h1000,
            {16'h1234, 16'h5677, 16'hABCD, 16'h8003});              // 32-bit pair
      issue(OP_FETCH, 64'h8000_0000_0000_0002,
            {16'h7FFC, 16'hC0DE, 16'hFFFF, 16'h0001});              // mixed 16/32/16
      issue(OP_FETCH, 64'h2000,
            {16'hFFFE, 16'h5555, 16'hAAAA, 16'h0002});              // fills the queue midway
      issue(OP_FETCH, 64'h3000, {4{16'h0001}});                     // queue full, nothing taken
      issue(OP_RELEASE, 64'h4000, 64'h0);
      issue(OP_FETCH, 64'h5000,
            {16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF});              // one 32-bit slot left
      for (int i = 0; i < 17; i++)                                  // drain, last one empty
         issue(OP_RELEASE, random_pc(), {$urandom, $urandom});

      // ---- random phases, one per limit setting ----
      foreach (limit_plan[p]) begin
         settle();
         csr_access(1'b1, CSR_DATA_W'(limit_plan[p]));
         csr_access(1'b0, '0);
         mood_left = 0;
         filling = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // alternate fill-heavy and drain-heavy stretches so the queue hits both ends,
            // and switch between gapped and back-to-back issue
            if (mood_left == 0) begin
               filling = ~filling;
               no_gaps = ($urandom_range(0, 3) == 0);
               mood_left = $urandom_range(15, 50);
            end
            mood_left--;
            fetch_pct = filling ? 55 : 10;
            op = ($urandom_range(0, 99) < fetch_pct) ? OP_FETCH : OP_RELEASE;
            issue(op, random_pc(),
                  {random_halfword(), random_halfword(), random_halfword(), random_halfword()});
         end
      end

      start = 1'b0;
      settle();
      repeat (10) @(negedge clock);

      $display("Covered %0d transactions over halfword limits 0..7 with random gaps.",
               transactions);
      $display("Queued %0d instructions (%0d 32-bit), released %0d,",
               insns_queued, wide_queued, insns_released);
      $display("  %0d empty releases, %0d full-queue cuts.", empty_releases, full_cuts);
      if (errors == 0)
         $display("[compressed_insn_fetch_queue_unit] OK");
      else
         $display("[compressed_insn_fetch_queue_unit] ERROR");
      $finish;
   end

   // watchdog: any stretch without a transaction or a reply this long is a hang
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("Watchdog: no transaction for %0d cycles, %0d replies outstanding",
                  idle_cycles, pending);
         $display("[compressed_insn_fetch_queue_unit] ERROR");
         $finish;
      end
   end

endmodule
